// File: design/swd_pkg.sv
// Shared types and constants for the stuck-CPU watchdog.
package swd_pkg;

  // command codes carried by an input item
  typedef enum logic [1:0] {
    CMD_HEARTBEAT = 2'd0,
    CMD_NMI       = 2'd1,
    CMD_DISABLE   = 2'd2,
    CMD_ENABLE    = 2'd3
  } cmd_t;

  // counter kinds for the overflow test
  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_CTRL31   = 2'd1,
    KIND_VARWIDTH = 2'd2,
    KIND_BIT32    = 2'd3
  } kind_t;

  // configuration register indexes
  localparam logic [7:0] REG_COUNTER_KIND     = 8'd0;
  localparam logic [7:0] REG_COUNTER_WIDTH    = 8'd1;
  localparam logic [7:0] REG_TIMEOUT_SECONDS  = 8'd2;
  localparam logic [7:0] REG_TICKS_PER_SECOND = 8'd3;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 10;

  localparam int unsigned HB_W    = 32;
  localparam int unsigned ALERT_W = 18;
  localparam int unsigned NEST_W  = 8;

  localparam logic [ALERT_W-1:0] ALERT_MAX = {ALERT_W{1'b1}};
  localparam logic [NEST_W-1:0]  NEST_MAX  = {NEST_W{1'b1}};

  localparam logic [6:0] WIDTH_MIN = 7'd32;
  localparam logic [6:0] WIDTH_MAX = 7'd64;

  typedef struct packed {
    kind_t      counter_kind;
    logic [6:0] counter_width;
    logic [7:0] timeout_seconds;
    logic [9:0] ticks_per_second;
  } cfg_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [63:0] counter_snapshot;
  } item_t;

  typedef struct packed {
    logic watchdog_nmi;
    logic cpu_stuck;
    logic watchdog_active;
    logic nest_error;
  } result_t;

endpackage

// File: design/swd_cfg.sv
// Configuration registers of the stuck-CPU watchdog.
module swd_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [swd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [swd_pkg::CFG_DATA_W-1:0]    cfg_data,
  output swd_pkg::cfg_t                     cfg
);

  // always take a write
  assign cfg_ready = 1'b1;

  // write the addressed register, ignore unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.counter_kind     <= swd_pkg::KIND_NONE;
      cfg.counter_width    <= 7'd32;
      cfg.timeout_seconds  <= 8'd5;
      cfg.ticks_per_second <= 10'd100;
    end else if (cfg_valid) begin
      case (cfg_index)
        swd_pkg::REG_COUNTER_KIND:     cfg.counter_kind     <= swd_pkg::kind_t'(cfg_data[1:0]);
        swd_pkg::REG_COUNTER_WIDTH:    cfg.counter_width    <= cfg_data[6:0];
        swd_pkg::REG_TIMEOUT_SECONDS:  cfg.timeout_seconds  <= cfg_data[7:0];
        swd_pkg::REG_TICKS_PER_SECOND: cfg.ticks_per_second <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

endmodule

// File: design/swd_core.sv
// Watchdog state and the per-item update and classification logic.
module swd_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  swd_pkg::item_t    item,
  input  swd_pkg::cfg_t     cfg,
  output swd_pkg::result_t  result
);

  logic [swd_pkg::HB_W-1:0]    heartbeat_count, heartbeat_count_next;
  logic [swd_pkg::HB_W-1:0]    last_heartbeat, last_heartbeat_next;
  logic [swd_pkg::ALERT_W-1:0] alert_count, alert_count_next;
  logic [swd_pkg::NEST_W-1:0]  disable_nest, disable_nest_next;

  logic [swd_pkg::ALERT_W-1:0] threshold;
  logic [6:0]                  width_clamped;
  logic [5:0]                  top_bit;
  logic                        tick;

  // stuck threshold: seconds times tick rate, fits in the alert width
  assign threshold = swd_pkg::ALERT_W'(cfg.timeout_seconds) *
                     swd_pkg::ALERT_W'(cfg.ticks_per_second);

  // clamp the variable counter width and pick its top bit
  always_comb begin
    if (cfg.counter_width < swd_pkg::WIDTH_MIN) width_clamped = swd_pkg::WIDTH_MIN;
    else if (cfg.counter_width > swd_pkg::WIDTH_MAX) width_clamped = swd_pkg::WIDTH_MAX;
    else width_clamped = cfg.counter_width;
  end
  assign top_bit = 6'(width_clamped - 7'd1);

  // classify the NMI from the snapshot overflow bit
  always_comb begin
    case (cfg.counter_kind)
      swd_pkg::KIND_CTRL31:   tick = item.counter_snapshot[31];
      swd_pkg::KIND_VARWIDTH: tick = ~item.counter_snapshot[top_bit];
      swd_pkg::KIND_BIT32:    tick = ~item.counter_snapshot[32];
      default:                tick = 1'b1;
    endcase
  end

  // next state and result for one item
  always_comb begin
    heartbeat_count_next = heartbeat_count;
    last_heartbeat_next  = last_heartbeat;
    alert_count_next     = alert_count;
    disable_nest_next    = disable_nest;
    result               = '0;
    case (item.cmd)
      swd_pkg::CMD_HEARTBEAT: begin
        heartbeat_count_next = heartbeat_count + 1'b1;
      end
      swd_pkg::CMD_NMI: begin
        if (last_heartbeat == heartbeat_count && disable_nest == '0) begin
          if (alert_count != swd_pkg::ALERT_MAX) alert_count_next = alert_count + 1'b1;
          result.cpu_stuck = (alert_count_next == threshold);
        end else begin
          last_heartbeat_next = heartbeat_count;
          alert_count_next    = '0;
        end
        result.watchdog_nmi = tick;
      end
      swd_pkg::CMD_DISABLE: begin
        if (disable_nest == swd_pkg::NEST_MAX) result.nest_error = 1'b1;
        else disable_nest_next = disable_nest + 1'b1;
      end
      default: begin
        if (disable_nest == '0) result.nest_error = 1'b1;
        else disable_nest_next = disable_nest - 1'b1;
      end
    endcase
    result.watchdog_active = (disable_nest_next == '0);
  end

  // advance state when an item is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      heartbeat_count <= '0;
      last_heartbeat  <= '0;
      alert_count     <= '0;
      disable_nest    <= swd_pkg::NEST_W'(1);
    end else if (fire) begin
      heartbeat_count <= heartbeat_count_next;
      last_heartbeat  <= last_heartbeat_next;
      alert_count     <= alert_count_next;
      disable_nest    <= disable_nest_next;
    end
  end

endmodule

// File: design/stuck_cpu_nmi_watchdog.sv
// Top level of the stuck-CPU watchdog: input register, core, result register.
// An item is held in the input register, then its result in the result register.
// Throughput: one item per cycle; the input stalls only while both the input
// register and the result register hold items and the result is not taken.
// Reset (rst, synchronous): heartbeat and alert state clear, nest count goes
// to one, configuration returns to kind 0, width 32, timeout 5, rate 100.
module stuck_cpu_nmi_watchdog (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      cmd,
  input  logic [63:0]                     counter_snapshot,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            watchdog_nmi,
  output logic                            cpu_stuck,
  output logic                            watchdog_active,
  output logic                            nest_error,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [swd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [swd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  swd_pkg::cfg_t    cfg;
  swd_pkg::item_t   item;
  swd_pkg::result_t result, result_q;
  logic             item_valid;
  logic             advance;

  swd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // the held item moves on when the result register is free or being taken
  assign advance  = ~out_valid | out_ready;
  assign in_ready = ~item_valid | advance;

  // hold the accepted item
  always_ff @(posedge clk) begin
    if (rst) item_valid <= 1'b0;
    else if (in_ready) item_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.cmd              <= swd_pkg::cmd_t'(cmd);
      item.counter_snapshot <= counter_snapshot;
    end
  end

  swd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (item_valid & advance),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  // hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (advance) out_valid <= item_valid;
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) result_q <= result;
  end

  assign watchdog_nmi    = result_q.watchdog_nmi;
  assign cpu_stuck       = result_q.cpu_stuck;
  assign watchdog_active = result_q.watchdog_active;
  assign nest_error      = result_q.nest_error;

endmodule
